>>> rtl/pfau_pkg.sv
// ----------------------------------------------------------------------------
// Prime field arithmetic unit package
// Shared widths, command and status codes, datapath operations, and the
// types that join the controller to the datapath.
// ----------------------------------------------------------------------------
package pfau_pkg;

  localparam int FIELD_W       = 63;
  localparam int MOD_WIDTH_DEF = 63;
  localparam int CMD_W         = 3;
  localparam int ST_W          = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEG = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INV = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POW = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NOINV = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RANGE,
    OP_SIMPLE,
    OP_MUL_LD_AB,
    OP_MUL_LD_RS,
    OP_MUL_LD_SS,
    OP_MUL_LD_QD,
    OP_MUL_DBL,
    OP_MUL_ADD,
    OP_MUL_OUT,
    OP_PW_INIT,
    OP_PW_SETR,
    OP_PW_SETS,
    OP_PW_OUT,
    OP_EU_INIT,
    OP_DIV_LD,
    OP_DIV_STEP,
    OP_EU_UPD,
    OP_EU_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             rng_err;
    logic             d_zero;
    logic             n_zero;
    logic             n_lsb;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_DBL,
    S_MUL_ADD,
    S_MUL_DONE,
    S_PW_TEST,
    S_EU_TEST,
    S_DIV_STEP,
    S_DIV_DONE,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    DEST_OUT,
    DEST_RES,
    DEST_SQ,
    DEST_EU
  } dest_t;

endpackage

>>> rtl/pfau_dpath.sv
// ----------------------------------------------------------------------------
// Prime field arithmetic unit datapath
// Modulus register, operand registers, a shift-and-add modular multiplier,
// a restoring divider and the Euclid and power registers.
// ----------------------------------------------------------------------------
module pfau_dpath #(
  parameter int MOD_WIDTH = pfau_pkg::MOD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pfau_pkg::FIELD_W-1:0]      cfg_data,
  input  logic [pfau_pkg::CMD_W-1:0]        in_cmd,
  input  logic [pfau_pkg::FIELD_W-1:0]      in_operand_a,
  input  logic [pfau_pkg::FIELD_W-1:0]      in_operand_b,
  input  pfau_pkg::dp_cmd_t                 ctl,
  output pfau_pkg::dp_stat_t                stat,
  output logic [pfau_pkg::FIELD_W-1:0]      value,
  output logic [pfau_pkg::ST_W-1:0]         status
);

  localparam int W  = MOD_WIDTH;
  localparam int FW = pfau_pkg::FIELD_W;

  function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] p);
    logic [W:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, p}) begin
      t = t - {1'b0, p};
    end
    return t[W-1:0];
  endfunction

  function automatic logic [W-1:0] msub(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] p);
    logic [W:0] t;
    if (x >= y) begin
      t = {1'b0, x} - {1'b0, y};
    end else begin
      t = {1'b0, x} + {1'b0, p} - {1'b0, y};
    end
    return t[W-1:0];
  endfunction

  logic [W-1:0]                  mod_r;
  logic [W-1:0]                  p_r, a_r, b_r;
  logic [FW-1:0]                 n_r;
  logic [pfau_pkg::CMD_W-1:0]    cmd_r;
  logic                          rng_r;
  logic [W-1:0]                  mx_r, my_r, macc_r;
  logic [W-1:0]                  res_r, s_r;
  logic [W-1:0]                  c_r, d_r, c1_r, d1_r;
  logic [W-1:0]                  dvd_r, rem_r, q_r;
  logic [W-1:0]                  val_r;
  logic [pfau_pkg::ST_W-1:0]     st_r;

  logic [W-1:0] p_eff;
  logic         uses_b, cmd_known, rng_nxt;
  logic [W:0]   div_t, div_sub;
  logic         div_ge;
  logic [W-1:0] dbl, addy, simple_val;

  always_comb begin
    p_eff     = (mod_r < W'(2)) ? W'(2) : mod_r;
    uses_b    = (in_cmd == pfau_pkg::CMD_ADD) || (in_cmd == pfau_pkg::CMD_SUB) ||
                (in_cmd == pfau_pkg::CMD_MUL);
    cmd_known = (in_cmd <= pfau_pkg::CMD_POW);
    rng_nxt   = cmd_known && ((in_operand_a >= FW'(p_eff)) ||
                              (uses_b && (in_operand_b >= FW'(p_eff))));
    div_t     = {rem_r, dvd_r[W-1]};
    div_ge    = (div_t >= {1'b0, d_r});
    div_sub   = div_t - {1'b0, d_r};
    dbl       = madd(macc_r, macc_r, p_r);
    addy      = madd(macc_r, my_r, p_r);
    case (cmd_r)
      pfau_pkg::CMD_ADD: simple_val = madd(a_r, b_r, p_r);
      pfau_pkg::CMD_SUB: simple_val = msub(a_r, b_r, p_r);
      pfau_pkg::CMD_NEG: simple_val = (a_r == '0) ? '0 : p_r - a_r;
      default:           simple_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(2);
    end else if (cfg_we) begin
      mod_r <= cfg_data[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      pfau_pkg::OP_LOAD: begin
        cmd_r <= in_cmd;
        a_r   <= in_operand_a[W-1:0];
        b_r   <= in_operand_b[W-1:0];
        n_r   <= in_operand_b;
        p_r   <= p_eff;
        rng_r <= rng_nxt;
      end
      pfau_pkg::OP_RANGE: begin
        val_r <= '0;
        st_r  <= pfau_pkg::ST_RANGE;
      end
      pfau_pkg::OP_SIMPLE: begin
        val_r <= simple_val;
        st_r  <= pfau_pkg::ST_OK;
      end
      pfau_pkg::OP_MUL_LD_AB: begin
        mx_r   <= a_r;
        my_r   <= b_r;
        macc_r <= '0;
      end
      pfau_pkg::OP_MUL_LD_RS: begin
        mx_r   <= res_r;
        my_r   <= s_r;
        macc_r <= '0;
      end
      pfau_pkg::OP_MUL_LD_SS: begin
        mx_r   <= s_r;
        my_r   <= s_r;
        macc_r <= '0;
      end
      pfau_pkg::OP_MUL_LD_QD: begin
        mx_r   <= q_r;
        my_r   <= d1_r;
        macc_r <= '0;
      end
      pfau_pkg::OP_MUL_DBL: begin
        macc_r <= dbl;
      end
      pfau_pkg::OP_MUL_ADD: begin
        if (mx_r[W-1]) begin
          macc_r <= addy;
        end
        mx_r <= mx_r << 1;
      end
      pfau_pkg::OP_MUL_OUT: begin
        val_r <= macc_r;
        st_r  <= pfau_pkg::ST_OK;
      end
      pfau_pkg::OP_PW_INIT: begin
        res_r <= W'(1);
        s_r   <= a_r;
      end
      pfau_pkg::OP_PW_SETR: begin
        // Store the product and start squaring the base at once.
        res_r  <= macc_r;
        mx_r   <= s_r;
        my_r   <= s_r;
        macc_r <= '0;
      end
      pfau_pkg::OP_PW_SETS: begin
        s_r <= macc_r;
        n_r <= n_r >> 1;
      end
      pfau_pkg::OP_PW_OUT: begin
        val_r <= res_r;
        st_r  <= pfau_pkg::ST_OK;
      end
      pfau_pkg::OP_EU_INIT: begin
        c_r  <= a_r;
        d_r  <= p_r;
        c1_r <= W'(1);
        d1_r <= '0;
      end
      pfau_pkg::OP_DIV_LD: begin
        dvd_r <= c_r;
        rem_r <= '0;
        q_r   <= '0;
      end
      pfau_pkg::OP_DIV_STEP: begin
        rem_r <= div_ge ? div_sub[W-1:0] : div_t[W-1:0];
        q_r   <= {q_r[W-2:0], div_ge};
        dvd_r <= dvd_r << 1;
      end
      pfau_pkg::OP_EU_UPD: begin
        // Bezout coefficients are kept reduced mod p.
        c_r  <= d_r;
        c1_r <= d1_r;
        d_r  <= rem_r;
        d1_r <= msub(c1_r, macc_r, p_r);
      end
      pfau_pkg::OP_EU_OUT: begin
        if (c_r == W'(1)) begin
          val_r <= c1_r;
          st_r  <= pfau_pkg::ST_OK;
        end else begin
          val_r <= '0;
          st_r  <= pfau_pkg::ST_NOINV;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.cmd     = cmd_r;
    stat.rng_err = rng_r;
    stat.d_zero  = (d_r == '0);
    stat.n_zero  = (n_r == '0);
    stat.n_lsb   = n_r[0];
    value        = FW'(val_r);
    status       = st_r;
  end

endmodule

>>> rtl/pfau_ctrl.sv
// ----------------------------------------------------------------------------
// Prime field arithmetic unit controller
// Sequences the datapath through multiply, divide, Euclid and power loops.
// ----------------------------------------------------------------------------
module pfau_ctrl #(
  parameter int MOD_WIDTH = pfau_pkg::MOD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  pfau_pkg::dp_stat_t stat,
  output pfau_pkg::dp_cmd_t  ctl
);

  localparam int CW = $clog2(MOD_WIDTH);

  pfau_pkg::state_t state_r, state_nxt;
  pfau_pkg::dest_t  dest_r, dest_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfau_pkg::S_IDLE;
      dest_r  <= pfau_pkg::DEST_OUT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dest_r  <= dest_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dest_nxt  = dest_r;
    cnt_nxt   = cnt_r;
    ctl.op    = pfau_pkg::OP_NONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      pfau_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.op    = pfau_pkg::OP_LOAD;
          state_nxt = pfau_pkg::S_CHECK;
        end
      end
      pfau_pkg::S_CHECK: begin
        cnt_nxt = CW'(MOD_WIDTH - 1);
        if (stat.rng_err) begin
          ctl.op    = pfau_pkg::OP_RANGE;
          state_nxt = pfau_pkg::S_RESULT;
        end else begin
          unique case (stat.cmd)
            pfau_pkg::CMD_MUL: begin
              ctl.op    = pfau_pkg::OP_MUL_LD_AB;
              dest_nxt  = pfau_pkg::DEST_OUT;
              state_nxt = pfau_pkg::S_MUL_DBL;
            end
            pfau_pkg::CMD_INV: begin
              ctl.op    = pfau_pkg::OP_EU_INIT;
              state_nxt = pfau_pkg::S_EU_TEST;
            end
            pfau_pkg::CMD_POW: begin
              ctl.op    = pfau_pkg::OP_PW_INIT;
              state_nxt = pfau_pkg::S_PW_TEST;
            end
            default: begin
              ctl.op    = pfau_pkg::OP_SIMPLE;
              state_nxt = pfau_pkg::S_RESULT;
            end
          endcase
        end
      end
      pfau_pkg::S_MUL_DBL: begin
        ctl.op    = pfau_pkg::OP_MUL_DBL;
        state_nxt = pfau_pkg::S_MUL_ADD;
      end
      pfau_pkg::S_MUL_ADD: begin
        ctl.op = pfau_pkg::OP_MUL_ADD;
        if (cnt_r == '0) begin
          state_nxt = pfau_pkg::S_MUL_DONE;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = pfau_pkg::S_MUL_DBL;
        end
      end
      pfau_pkg::S_MUL_DONE: begin
        cnt_nxt = CW'(MOD_WIDTH - 1);
        unique case (dest_r)
          pfau_pkg::DEST_OUT: begin
            ctl.op    = pfau_pkg::OP_MUL_OUT;
            state_nxt = pfau_pkg::S_RESULT;
          end
          pfau_pkg::DEST_RES: begin
            ctl.op    = pfau_pkg::OP_PW_SETR;
            dest_nxt  = pfau_pkg::DEST_SQ;
            state_nxt = pfau_pkg::S_MUL_DBL;
          end
          pfau_pkg::DEST_SQ: begin
            ctl.op    = pfau_pkg::OP_PW_SETS;
            state_nxt = pfau_pkg::S_PW_TEST;
          end
          default: begin
            ctl.op    = pfau_pkg::OP_EU_UPD;
            state_nxt = pfau_pkg::S_EU_TEST;
          end
        endcase
      end
      pfau_pkg::S_PW_TEST: begin
        cnt_nxt = CW'(MOD_WIDTH - 1);
        if (stat.n_zero) begin
          ctl.op    = pfau_pkg::OP_PW_OUT;
          state_nxt = pfau_pkg::S_RESULT;
        end else if (stat.n_lsb) begin
          ctl.op    = pfau_pkg::OP_MUL_LD_RS;
          dest_nxt  = pfau_pkg::DEST_RES;
          state_nxt = pfau_pkg::S_MUL_DBL;
        end else begin
          ctl.op    = pfau_pkg::OP_MUL_LD_SS;
          dest_nxt  = pfau_pkg::DEST_SQ;
          state_nxt = pfau_pkg::S_MUL_DBL;
        end
      end
      pfau_pkg::S_EU_TEST: begin
        cnt_nxt = CW'(MOD_WIDTH - 1);
        if (stat.d_zero) begin
          ctl.op    = pfau_pkg::OP_EU_OUT;
          state_nxt = pfau_pkg::S_RESULT;
        end else begin
          ctl.op    = pfau_pkg::OP_DIV_LD;
          state_nxt = pfau_pkg::S_DIV_STEP;
        end
      end
      pfau_pkg::S_DIV_STEP: begin
        ctl.op = pfau_pkg::OP_DIV_STEP;
        if (cnt_r == '0) begin
          state_nxt = pfau_pkg::S_DIV_DONE;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      pfau_pkg::S_DIV_DONE: begin
        ctl.op    = pfau_pkg::OP_MUL_LD_QD;
        cnt_nxt   = CW'(MOD_WIDTH - 1);
        dest_nxt  = pfau_pkg::DEST_EU;
        state_nxt = pfau_pkg::S_MUL_DBL;
      end
      pfau_pkg::S_RESULT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = pfau_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pfau_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/prime_field_arith_unit.sv
// Add, subtract, negate and out-of-range requests pass through the load and check states to the result;
// a multiply runs the shift-and-add multiplier loop over all MOD_WIDTH bits of the first operand.
// A power does one multiply per zero exponent bit and two per one bit (square, or multiply and square).
// An inverse runs the divider and then the multiplier for each Euclid division step.
// One request is in flight at a time; the next is accepted after the result is taken.
// Reset (synchronous, rst_n low) returns the controller to idle and sets the modulus to 2.
// ----------------------------------------------------------------------------
// Prime field arithmetic unit
// Add, subtract, negate, multiply, inverse and power of integers mod p with a
// configurable modulus p. A controller state machine drives a datapath that
// holds one shared modular multiplier and one restoring divider.
// ----------------------------------------------------------------------------
module prime_field_arith_unit #(
  parameter int MOD_WIDTH = pfau_pkg::MOD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write channel, carrying the modulus.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfau_pkg::FIELD_W-1:0]  cfg_data,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfau_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pfau_pkg::FIELD_W-1:0]  in_operand_a,
  input  logic [pfau_pkg::FIELD_W-1:0]  in_operand_b,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfau_pkg::FIELD_W-1:0]  out_value,
  output logic [pfau_pkg::ST_W-1:0]     out_status
);

  pfau_pkg::dp_cmd_t  ctl;
  pfau_pkg::dp_stat_t stat;
  logic               cfg_we;

  // The modulus register takes a write in any cycle. The user issues writes only while the unit
  // is idle, which the block does not enforce; a running operation uses the p latched at load.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // The controller owns the handshakes and the loop counters. The result
  // registers live in the datapath and stay stable while out_valid is high,
  // because the controller issues no datapath operation in the result state.
  pfau_ctrl #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // The datapath reduces everything mod p: the inverse keeps its Bezout
  // coefficients reduced, so no signed arithmetic is needed anywhere.
  pfau_dpath #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_cmd       (in_cmd),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .ctl          (ctl),
    .stat         (stat),
    .value        (out_value),
    .status       (out_status)
  );

endmodule

>>> tb/sv/prime_field_arith_unit_tb.sv
// ----------------------------------------------------------------------------
// Prime field arithmetic unit testbench
// Drives add, subtract, negate, multiply, inverse and power requests under
// several moduli, with random gaps on requests and random result stalls, and checks
// every result against a predictor of arithmetic mod p or a typed-in value.
// ----------------------------------------------------------------------------
module prime_field_arith_unit_tb;

  localparam int FIELD_W = pfau_pkg::FIELD_W;
  localparam int CMD_W   = pfau_pkg::CMD_W;
  localparam int ST_W    = pfau_pkg::ST_W;

  // Command codes the block does not use; they answer zero with status ok.
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam logic [FIELD_W-1:0] ALL_ONES = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] MERSENNE61 = 63'h1FFF_FFFF_FFFF_FFFF;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [FIELD_W-1:0]  cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [FIELD_W-1:0]  in_operand_a = '0;
  logic [FIELD_W-1:0]  in_operand_b = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FIELD_W-1:0]  out_value;
  logic [ST_W-1:0]     out_status;

  prime_field_arith_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_status   (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [FIELD_W-1:0] value;
    logic [ST_W-1:0]    status;
  } field_result_t;

  // One row of the directed table: either a modulus write or a request, with
  // the expected result typed in where it is obvious.
  typedef struct {
    bit                 is_mod_write;
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    bit                 typed;
    logic [FIELD_W-1:0] value;
    logic [ST_W-1:0]    status;
  } stim_row_t;

  field_result_t      pending_results[$];
  stim_row_t          directed_rows[$];
  logic [FIELD_W-1:0] modulus_reg = 63'd2;
  bit                 failed = 1'b0;
  bit                 hold_request = 1'b0;
  int                 hold_count = 0;
  int                 stall_run = 0;
  int                 idle_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [FIELD_W-1:0] mul_mod(logic [FIELD_W-1:0] x,
                                                 logic [FIELD_W-1:0] y,
                                                 logic [FIELD_W-1:0] p);
    logic [2*FIELD_W-1:0] prod;
    logic [2*FIELD_W-1:0] rem;
    prod = {{FIELD_W{1'b0}}, x} * {{FIELD_W{1'b0}}, y};
    rem = prod % {{FIELD_W{1'b0}}, p};
    return rem[FIELD_W-1:0];
  endfunction

  function automatic field_result_t field_op(logic [CMD_W-1:0] cmd,
                                             logic [FIELD_W-1:0] a,
                                             logic [FIELD_W-1:0] b,
                                             logic [FIELD_W-1:0] mod_reg);
    field_result_t      res;
    logic [FIELD_W-1:0] p;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] expo;
    logic [FIELD_W:0]   sum;
    longint             c, d, c1, d1, q, r, r1;
    bit                 uses_b;
    p = (mod_reg < 2) ? 63'd2 : mod_reg;
    res.value = '0;
    res.status = pfau_pkg::ST_OK;
    uses_b = (cmd == pfau_pkg::CMD_ADD) || (cmd == pfau_pkg::CMD_SUB) ||
             (cmd == pfau_pkg::CMD_MUL);
    if (cmd <= pfau_pkg::CMD_POW && (a >= p || (uses_b && b >= p))) begin
      res.status = pfau_pkg::ST_RANGE;
      return res;
    end
    case (cmd)
      pfau_pkg::CMD_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        res.value = (sum >= {1'b0, p}) ? FIELD_W'(sum - {1'b0, p}) : sum[FIELD_W-1:0];
      end
      pfau_pkg::CMD_SUB: res.value = (a >= b) ? a - b : a + (p - b);
      pfau_pkg::CMD_NEG: res.value = (a == 0) ? '0 : p - a;
      pfau_pkg::CMD_MUL: res.value = mul_mod(a, b, p);
      pfau_pkg::CMD_INV: begin
        c = longint'(a);
        d = longint'(p);
        c1 = 1;
        d1 = 0;
        while (d != 0) begin
          q = c / d;
          r = c - q * d;
          r1 = c1 - q * d1;
          c = d;
          c1 = d1;
          d = r;
          d1 = r1;
        end
        if (c != 1) begin
          res.status = pfau_pkg::ST_NOINV;
        end else begin
          if (c1 < 0) c1 += longint'(p);
          res.value = FIELD_W'(c1);
        end
      end
      pfau_pkg::CMD_POW: begin
        res.value = 63'd1 % p;
        base = a;
        expo = b;
        while (expo != 0) begin
          if (expo[0]) res.value = mul_mod(res.value, base, p);
          base = mul_mod(base, base, p);
          expo = expo >> 1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------ drivers
  task automatic write_modulus(logic [FIELD_W-1:0] m);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = m;
    do @(posedge clk); while (!cfg_ready);
    modulus_reg = m;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits until every result has come back, so the block is idle.
  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offers one request; returns at the falling edge after it was accepted,
  // with valid still high so a back-to-back request needs no second toggle.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] a,
                              logic [FIELD_W-1:0] b, bit typed,
                              field_result_t typed_res);
    int            gap;
    field_result_t res;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) :
          ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_operand_a = a;
    in_operand_b = b;
    do @(posedge clk); while (in_stall);
    res = typed ? typed_res : field_op(cmd, a, b, modulus_reg);
    pending_results.push_back(res);
    @(negedge clk);
  endtask

  task automatic add_row(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] a,
                         logic [FIELD_W-1:0] b, bit typed,
                         logic [FIELD_W-1:0] value, logic [ST_W-1:0] status);
    stim_row_t row;
    row = '{1'b0, cmd, a, b, typed, value, status};
    directed_rows.push_back(row);
  endtask

  task automatic add_mod_row(logic [FIELD_W-1:0] m);
    stim_row_t row;
    row = '{1'b1, pfau_pkg::CMD_ADD, m, '0, 1'b0, '0, pfau_pkg::ST_OK};
    directed_rows.push_back(row);
  endtask

  function automatic logic [FIELD_W-1:0] rand_field();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  // Mostly in-range operands; one in eight is raw so range errors show up.
  function automatic logic [FIELD_W-1:0] rand_operand(logic [FIELD_W-1:0] p);
    if ($urandom_range(0, 7) == 0) return rand_field();
    return rand_field() % p;
  endfunction

  task automatic random_phase(logic [FIELD_W-1:0] m, int count);
    logic [FIELD_W-1:0] p;
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] a, b;
    field_result_t      none;
    none = '{'0, pfau_pkg::ST_OK};
    drain();
    in_valid = 1'b0;
    write_modulus(m);
    p = (m < 2) ? 63'd2 : m;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 19) == 0) ? CMD_W'(CMD_RSVD6 + $urandom_range(0, 1)) :
            CMD_W'($urandom_range(0, 5));
      a = rand_operand(p);
      b = rand_operand(p);
      // Exponents are kept short most of the time; a full-width power costs up to
      // two modular multiplies per exponent bit.
      if (cmd == pfau_pkg::CMD_POW) begin
        b = ($urandom_range(0, 7) == 0) ? rand_field() : FIELD_W'($urandom_range(0, 65535));
      end
      send_request(cmd, a, b, 1'b0, none);
    end
    in_valid = 1'b0;
  endtask

  // ------------------------------------------------------------ result stall
  // Random stall on the result channel, with now and then a run of stalled
  // cycles, and the long hold-off requested by the main sequence, which
  // starts once a result is waiting.
  always @(negedge clk) begin
    int mode;
    if (hold_request && hold_count == 0 && out_valid) begin
      hold_count = HOLD_CYCLES;
    end
    if (hold_count > 0) begin
      out_stall <= 1'b1;
      hold_count--;
      if (hold_count == 0) hold_request = 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else begin
      mode = $urandom_range(0, 9);
      if (mode < 5) out_stall <= 1'b0;
      else if (mode < 9) out_stall <= ($urandom_range(0, 1) == 0);
      else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(10, 40);
      end
    end
  end

  // ------------------------------------------------------------------ checker
  always @(posedge clk) begin
    field_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: value %h status %0d",
                 $time, out_value, out_status);
        failed = 1'b1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_value !== exp_res.value) begin
          $display("%0t: value mismatch: expected %h actual %h",
                   $time, exp_res.value, out_value);
          failed = 1'b1;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, exp_res.status, out_status);
          failed = 1'b1;
        end
      end
    end
  end

  // A long stretch with no request moving on any channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("prime_field_arith_unit regression: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------ main sequence
  initial begin
    field_result_t typed_res;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset the modulus is 2, so every result is obvious.
    add_row(pfau_pkg::CMD_ADD, 63'd1,    63'd1,    1, 63'd0, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_SUB, 63'd0,    63'd1,    1, 63'd1, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_NEG, 63'd1,    63'd0,    1, 63'd1, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_MUL, 63'd1,    63'd1,    1, 63'd1, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_INV, 63'd0,    63'd0,    1, 63'd0, pfau_pkg::ST_NOINV);
    add_row(pfau_pkg::CMD_INV, 63'd1,    ALL_ONES, 1, 63'd1, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_POW, 63'd0,    63'd0,    1, 63'd1, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_POW, 63'd1,    ALL_ONES, 1, 63'd1, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_ADD, 63'd2,    63'd0,    1, 63'd0, pfau_pkg::ST_RANGE);
    add_row(pfau_pkg::CMD_NEG, 63'd0,    ALL_ONES, 1, 63'd0, pfau_pkg::ST_OK);
    add_row(CMD_RSVD6,         63'd1,    63'd1,    1, 63'd0, pfau_pkg::ST_OK);
    add_row(CMD_RSVD7,         ALL_ONES, ALL_ONES, 1, 63'd0, pfau_pkg::ST_OK);
    // Largest modulus: operand extremes.
    add_mod_row(ALL_ONES);
    add_row(pfau_pkg::CMD_ADD, ALL_ONES - 1, ALL_ONES - 1, 1, ALL_ONES - 2, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_SUB, 63'd0,        63'd1,        1, ALL_ONES - 1, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_MUL, ALL_ONES - 1, ALL_ONES - 1, 1, 63'd1,        pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_INV, ALL_ONES - 1, 63'd0,        1, ALL_ONES - 1, pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_MUL, ALL_ONES,     63'd0,        1, 63'd0, pfau_pkg::ST_RANGE);
    add_row(pfau_pkg::CMD_SUB, 63'd0,        ALL_ONES,     1, 63'd0, pfau_pkg::ST_RANGE);
    // Seven divides 2^63-1, so there is no inverse.
    add_row(pfau_pkg::CMD_INV, 63'd7,        63'd0,        1, 63'd0, pfau_pkg::ST_NOINV);
    add_row(pfau_pkg::CMD_POW, ALL_ONES - 2, ALL_ONES,     0, '0,    pfau_pkg::ST_OK);
    add_row(pfau_pkg::CMD_POW, 63'd3,        63'd5,        1, 63'd243, pfau_pkg::ST_OK);
    // Register values of zero and one act as a modulus of two.
    add_mod_row(63'd0);
    add_row(pfau_pkg::CMD_ADD, 63'd1, 63'd1, 1, 63'd0, pfau_pkg::ST_OK);
    add_mod_row(63'd1);
    add_row(pfau_pkg::CMD_INV, 63'd1, 63'd0, 1, 63'd1, pfau_pkg::ST_OK);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_mod_write) begin
        in_valid = 1'b0;
        drain();
        write_modulus(directed_rows[i].a);
      end else begin
        typed_res = '{directed_rows[i].value, directed_rows[i].status};
        send_request(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                     directed_rows[i].typed, typed_res);
      end
    end
    in_valid = 1'b0;

    // The sender keeps offering requests while the receiver holds off, so
    // the block fills and stalls its input.
    drain();
    hold_request = 1'b1;
    random_phase(MERSENNE61, 19);
    random_phase(rand_field() | 63'h4000_0000_0000_0000, 19);
    random_phase(63'd2 + $urandom_range(0, 253), 19);
    random_phase(ALL_ONES, 19);

    drain();
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("prime_field_arith_unit regression: pass");
    end else begin
      $display("prime_field_arith_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pfau_pkg.sv
rtl/pfau_dpath.sv
rtl/pfau_ctrl.sv
rtl/prime_field_arith_unit.sv
tb/sv/prime_field_arith_unit_tb.sv
